### rtl/lkh_pkg.sv
// ----------------------------------------------------------------------------
// lkh_pkg
// Shared types and codes for the link keepalive handshake unit.
// ----------------------------------------------------------------------------
package lkh_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CODE_W   = 32;
    localparam int unsigned POLL_W   = 16;
    localparam int unsigned TRIES_W  = 8;
    localparam int unsigned TXCODE_W = 4;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 16;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 48;

    // register indexes of the configuration port
    typedef logic [CFG_AW-1:0] cfg_addr_t;
    localparam cfg_addr_t REG_IS_MASTER = 2'd0;
    localparam cfg_addr_t REG_POLL_TIME = 2'd1;
    localparam cfg_addr_t REG_MAX_TRIES = 2'd2;

    // radio control codes
    typedef logic [TXCODE_W-1:0] code_t;
    localparam code_t CODE_NONE      = 4'd0;
    localparam code_t CODE_HELLO_M   = 4'd5;   // hello, i am controller
    localparam code_t CODE_HELLO_S   = 4'd6;   // hello controller
    localparam code_t CODE_ARE_YOU_OK = 4'd7;
    localparam code_t CODE_I_AM_OK   = 4'd8;
    localparam code_t CODE_STILL_HERE = 4'd9;
    localparam code_t CODE_I_AM_HERE = 4'd10;

    localparam logic [TRIES_W-1:0] TRIES_ONE        = 8'd1;
    localparam logic [TRIES_W-1:0] TRIES_MAYBE_LOST = 8'd2;
    localparam logic [TRIES_W-1:0] TRIES_SAT        = 8'd255;

    typedef enum logic [2:0] {
        ST_SEARCHING = 3'd0,
        ST_FOUND     = 3'd1,
        ST_CONNECTED = 3'd2,
        ST_MAYLOST   = 3'd3,
        ST_LOST      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        RX_NONE  = 2'd0,
        RX_OWN   = 2'd1,
        RX_OTHER = 2'd2,
        RX_USER  = 2'd3
    } rx_kind_t;

    typedef struct packed {
        logic               is_master;
        logic [POLL_W-1:0]  poll_time_ms;
        logic [TRIES_W-1:0] max_tries;
    } cfg_t;

    // one classified request between front and back
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [CODE_W-1:0] rx_code;
        rx_kind_t          kind;
        code_t             rec;            // control code of the far side, else none
        logic              clear_pending;
    } item_t;

endpackage

### rtl/link_keepalive_handshake_unit.sv
// ----------------------------------------------------------------------------
// link_keepalive_handshake_unit
// Keepalive manager for a radio link, master or slave side.
//
//   channel   dir   handshake           payload
//   s_        in    s_tvalid/s_tready   one poll request (time, rx code, clear)
//   m_        out   m_tvalid/m_tready   one result per poll (status, tx, user)
//   cfg_      in    cfg_we              register write, no read-back
//
// one poll per cycle sustained while m_tready stays high; a poll passes from s_
// accept to m_ through the input register, two-entry queue and result register
// the engine in the back stage is a combinational update of the link state
// aresetn is synchronous; it clears the link state and restores the default
// registers (master, 1000 ms poll, 3 tries)
// a stalled m_ side fills the result register, then the queue, then the
// input register before s_tready drops
// ----------------------------------------------------------------------------
module link_keepalive_handshake_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // poll requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] now_ms, [32] rx_valid, [64:33] rx_code, [65] clear_pending, rest zero
    input  logic [lkh_pkg::S_DATA_W-1:0]  s_tdata,
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] link_status, [3] tx_valid, [7:4] tx_code, [8] user_pending,
    // [40:9] user_value, rest zero
    output logic [lkh_pkg::M_DATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [lkh_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [lkh_pkg::CFG_DW-1:0]    cfg_wdata
);
    import lkh_pkg::*;

    cfg_t  cfg_reg, cfg_next;

    logic  f_valid, f_ready;
    item_t f_item;
    logic  b_valid, b_ready;
    item_t b_item;

    logic [2:0]          link_status;
    logic                tx_valid;
    code_t               tx_code;
    logic                user_pending;
    logic [CODE_W-1:0]   user_value;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_IS_MASTER: cfg_next.is_master    = cfg_wdata[0];
                REG_POLL_TIME: cfg_next.poll_time_ms = cfg_wdata;
                REG_MAX_TRIES: cfg_next.max_tries    = cfg_wdata[TRIES_W-1:0];
                default: ;  // index beyond the list is dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.is_master    <= 1'b1;
            cfg_reg.poll_time_ms <= 16'd1000;
            cfg_reg.max_tries    <= 8'd3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and sort the received code
    lkh_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .now_ms        (s_tdata[31:0]),
        .rx_valid      (s_tdata[32]),
        .rx_code       (s_tdata[64:33]),
        .clear_pending (s_tdata[65]),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_item        (f_item)
    );

    // queue decouples the two halves
    lkh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    // back: link state update and result register
    lkh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_item       (b_item),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .link_status  (link_status),
        .tx_valid     (tx_valid),
        .tx_code      (tx_code),
        .user_pending (user_pending),
        .user_value   (user_value)
    );

    assign m_tdata = {7'd0, user_value, user_pending, tx_code, tx_valid, link_status};

endmodule

### rtl/lkh_front.sv
// ----------------------------------------------------------------------------
// lkh_front
// Input stage: takes a poll request and sorts its received code.
// ----------------------------------------------------------------------------
module lkh_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lkh_pkg::cfg_t           cfg,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [lkh_pkg::TIME_W-1:0] now_ms,
    input  logic                    rx_valid,
    input  logic [lkh_pkg::CODE_W-1:0] rx_code,
    input  logic                    clear_pending,
    output logic                    q_valid,
    input  logic                    q_ready,
    output lkh_pkg::item_t          q_item
);
    import lkh_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  accept;
    logic  m_code, s_code, own, other;

    assign s_tready = !valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb begin
        m_code = (rx_code == {28'd0, CODE_HELLO_M}) || (rx_code == {28'd0, CODE_ARE_YOU_OK})
              || (rx_code == {28'd0, CODE_STILL_HERE});
        s_code = (rx_code == {28'd0, CODE_HELLO_S}) || (rx_code == {28'd0, CODE_I_AM_OK})
              || (rx_code == {28'd0, CODE_I_AM_HERE});
        own    = cfg.is_master ? m_code : s_code;
        other  = cfg.is_master ? s_code : m_code;

        item_next               = item_reg;
        item_next.now_ms        = now_ms;
        item_next.rx_code       = rx_code;
        item_next.clear_pending = clear_pending;
        item_next.rec           = CODE_NONE;
        if (!rx_valid) begin
            item_next.kind = RX_NONE;
        end else if (other) begin
            item_next.kind = RX_OTHER;
            item_next.rec  = rx_code[TXCODE_W-1:0];
        end else if (own) begin
            item_next.kind = RX_OWN;
        end else begin
            item_next.kind = RX_USER;
        end

        if (accept) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/lkh_queue.sv
// ----------------------------------------------------------------------------
// lkh_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module lkh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lkh_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output lkh_pkg::item_t out_item
);
    import lkh_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/lkh_back.sv
// ----------------------------------------------------------------------------
// lkh_back
// Handshake engine: link state, retries, timeouts and the result register.
// ----------------------------------------------------------------------------
module lkh_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  lkh_pkg::cfg_t  cfg,
    input  logic           q_valid,
    output logic           q_ready,
    input  lkh_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [2:0]     link_status,
    output logic           tx_valid,
    output logic [lkh_pkg::TXCODE_W-1:0] tx_code,
    output logic           user_pending,
    output logic [lkh_pkg::CODE_W-1:0] user_value
);
    import lkh_pkg::*;

    status_t                  status_reg, status_next;
    logic [TRIES_W-1:0]       try_reg, try_next;
    logic [TIME_W-1:0]        last_poll_reg, last_poll_next;
    logic                     pend_reg, pend_next;
    logic [CODE_W-1:0]        uval_reg, uval_next;
    logic                     m_valid_reg, m_valid_next;
    code_t                    tx_code_reg, tx_next;

    // timeout thresholds are registered from the configuration and follow it in the next cycle
    logic [POLL_W+TRIES_W-1:0] lost_thr_reg;
    logic [POLL_W:0]           maybe_thr_reg;

    logic               advance;
    logic [TIME_W-1:0]  elapsed;
    logic               over_poll, over_lost, over_may;
    logic               act, linked;
    logic [TRIES_W-1:0] try0, try_inc;
    logic               try_lt_max;
    code_t              rec;

    assign q_ready = !m_valid_reg || m_tready;
    assign advance = q_valid && q_ready;
    assign rec     = q_item.rec;

    always_comb begin
        elapsed    = q_item.now_ms - last_poll_reg;
        over_poll  = elapsed > {16'd0, cfg.poll_time_ms};
        over_lost  = elapsed > {8'd0, lost_thr_reg};
        over_may   = elapsed > {15'd0, maybe_thr_reg};
        act        = (rec != CODE_NONE) || over_poll;
        linked     = (status_reg == ST_CONNECTED) || (status_reg == ST_MAYLOST);
        try0       = (q_item.kind == RX_OTHER) ? '0 : try_reg;
        try_inc    = (try0 == TRIES_SAT) ? try0 : try0 + TRIES_ONE;
        try_lt_max = try0 < cfg.max_tries;
    end

    // reception side: pending flag and stored user value
    always_comb begin
        pend_next = q_item.clear_pending ? 1'b0 : pend_reg;
        uval_next = uval_reg;
        case (q_item.kind) inside
            RX_OWN, RX_OTHER: pend_next = 1'b0;
            RX_USER: begin
                pend_next = 1'b1;
                uval_next = q_item.rx_code;
            end
            default: ;
        endcase
    end

    // next link state
    always_comb begin
        status_next    = status_reg;
        try_next       = try0;
        last_poll_next = last_poll_reg;
        if (cfg.is_master) begin
            if (act) begin
                last_poll_next = q_item.now_ms;
                if (!linked) begin
                    if (rec == CODE_HELLO_S) begin
                        status_next = ST_FOUND;
                        try_next    = try_inc;
                    end else if (rec == CODE_I_AM_OK) begin
                        status_next = ST_CONNECTED;
                    end else begin
                        try_next = try_inc;
                    end
                end else if (rec == CODE_I_AM_HERE) begin
                    try_next    = '0;
                    status_next = ST_CONNECTED;
                end else if (try_lt_max) begin
                    try_next = try_inc;
                    if (try_inc == TRIES_ONE) begin
                        status_next = ST_CONNECTED;
                    end else if (try_inc == TRIES_MAYBE_LOST) begin
                        status_next = ST_MAYLOST;
                    end
                end else begin
                    status_next = ST_LOST;
                end
            end
        end else begin
            if (rec == CODE_HELLO_M) begin
                status_next    = ST_FOUND;
                last_poll_next = q_item.now_ms;
            end else if (rec == CODE_ARE_YOU_OK || rec == CODE_STILL_HERE) begin
                status_next    = ST_CONNECTED;
                last_poll_next = q_item.now_ms;
            end else if (over_lost) begin
                status_next    = ST_LOST;
                last_poll_next = q_item.now_ms;
            end else if (over_may) begin
                status_next = ST_MAYLOST;
            end
        end
    end

    // code to transmit
    always_comb begin
        tx_next = CODE_NONE;
        if (cfg.is_master) begin
            if (act) begin
                if (!linked) begin
                    if (rec == CODE_HELLO_S) begin
                        tx_next = CODE_ARE_YOU_OK;
                    end else if (rec != CODE_I_AM_OK) begin
                        tx_next = CODE_HELLO_M;
                    end
                end else if (rec != CODE_I_AM_HERE && try_lt_max) begin
                    tx_next = CODE_STILL_HERE;
                end
            end
        end else begin
            if (rec == CODE_HELLO_M) begin
                tx_next = CODE_HELLO_S;
            end else if (rec == CODE_ARE_YOU_OK) begin
                tx_next = CODE_I_AM_OK;
            end else if (rec == CODE_STILL_HERE) begin
                tx_next = CODE_I_AM_HERE;
            end
        end
    end

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= ST_SEARCHING;
            try_reg       <= '0;
            last_poll_reg <= '0;
            pend_reg      <= 1'b0;
            uval_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                status_reg    <= status_next;
                try_reg       <= try_next;
                last_poll_reg <= last_poll_next;
                pend_reg      <= pend_next;
                uval_reg      <= uval_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lost_thr_reg  <= cfg.poll_time_ms * cfg.max_tries;
        maybe_thr_reg <= {1'b0, cfg.poll_time_ms} + {2'b0, cfg.poll_time_ms[POLL_W-1:1]};
        if (advance) begin
            tx_code_reg <= tx_next;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign link_status  = status_reg;
    assign tx_code      = tx_code_reg;
    assign tx_valid     = (tx_code_reg != CODE_NONE);
    assign user_pending = pend_reg;
    assign user_value   = uval_reg;

`ifndef NO_ASSERTIONS
    // link state never leaves the five defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg == ST_SEARCHING || status_reg == ST_FOUND || status_reg == ST_CONNECTED
        || status_reg == ST_MAYLOST || status_reg == ST_LOST)
        else $error("link status out of range");

    // a sent code is always a control code
    a_tx_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && tx_valid |-> (tx_code >= CODE_HELLO_M && tx_code <= CODE_I_AM_HERE))
        else $error("transmit code outside control range");

    // state only moves when a request is processed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(try_reg) && $stable(last_poll_reg) && $stable(pend_reg))
        else $error("state changed without a request");

    // user data always raises the pending flag
    a_user_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && q_item.kind == RX_USER |=> pend_reg)
        else $error("user data did not set pending flag");
`endif

endmodule

### bench/tb_link_keepalive_handshake_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_link_keepalive_handshake_unit
// Self-checking bench for the link keepalive handshake unit. A queue of poll
// requests feeds a stream driver; a clocked monitor runs its own model of the
// link state for every accepted poll and checks each result field by field.
// A short directed run walks the master through search, connect, probe and
// loss. Random phases follow, in master and slave roles, with default and
// extreme poll times and try limits and with try count saturation.
// ----------------------------------------------------------------------------
module tb_link_keepalive_handshake_unit;

    import lkh_pkg::*;

    localparam int unsigned LATENCY_SLACK = 8;
    localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;
    localparam cfg_addr_t REG_UNMAPPED = 2'd3;            // no register here

    // poll request, packed as on s_tdata, fields listed from the highest bit down
    typedef struct packed {
        logic              clear_pending;
        logic [CODE_W-1:0] rx_code;
        logic              rx_valid;
        logic [TIME_W-1:0] now_ms;
    } poll_req_t;

    // poll result, packed as on m_tdata, fields listed from the highest bit down
    typedef struct packed {
        logic [CODE_W-1:0] user_value;
        logic              user_pending;
        code_t             tx_code;
        logic              tx_valid;
        status_t           link_status;
    } poll_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we = 1'b0;
    cfg_addr_t            cfg_addr = REG_IS_MASTER;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    // model of the link: configuration
    logic                 master_mode = 1'b1;
    logic [POLL_W-1:0]    poll_ms = 16'd1000;
    logic [TRIES_W-1:0]   try_limit = 8'd3;
    // model of the link: state
    status_t              link_state = ST_SEARCHING;
    logic [TRIES_W-1:0]   tries = '0;
    logic [TIME_W-1:0]    last_poll = '0;
    logic                 pending = 1'b0;
    logic [CODE_W-1:0]    user_val = '0;

    poll_req_t            poll_requests[$];   // waiting to be driven
    poll_result_t         poll_outcomes[$];   // predicted, waiting for m_
    logic [TIME_W-1:0]    stim_now = '0;      // running time stamp of stimulus
    logic                 s_taken = 1'b0;     // request accepted at last edge
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          mismatch_count = 0;

    link_keepalive_handshake_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // control code of one side: hello, probe or still-here (master),
    // or the matching answer (slave)
    function automatic code_t side_code(logic master_side, int unsigned sel);
        case (sel)
            0:       return master_side ? CODE_HELLO_M    : CODE_HELLO_S;
            1:       return master_side ? CODE_ARE_YOU_OK : CODE_I_AM_OK;
            default: return master_side ? CODE_STILL_HERE : CODE_I_AM_HERE;
        endcase
    endfunction

    function automatic logic is_side_code(logic master_side, logic [CODE_W-1:0] c);
        return c == CODE_W'(side_code(master_side, 0))
            || c == CODE_W'(side_code(master_side, 1))
            || c == CODE_W'(side_code(master_side, 2));
    endfunction

    // one poll through the link model; updates the model state
    function automatic poll_result_t predict_poll(poll_req_t req);
        code_t             far_code;
        code_t             send;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] lost_after;
        logic [TIME_W-1:0] maybe_after;
        poll_result_t      res;
        far_code    = CODE_NONE;
        send        = CODE_NONE;
        lost_after  = TIME_W'(poll_ms) * TIME_W'(try_limit);
        maybe_after = TIME_W'(poll_ms) + TIME_W'(poll_ms >> 1);

        // acknowledge goes first, then the received code is sorted
        if (req.clear_pending)
            pending = 1'b0;
        if (req.rx_valid) begin
            if (is_side_code(!master_mode, req.rx_code)) begin
                tries    = '0;
                pending  = 1'b0;
                far_code = code_t'(req.rx_code[TXCODE_W-1:0]);
            end else if (is_side_code(master_mode, req.rx_code)) begin
                // own-side code only clears the pending flag
                pending = 1'b0;
            end else begin
                pending  = 1'b1;
                user_val = req.rx_code;
            end
        end

        elapsed = req.now_ms - last_poll;   // wraps modulo 2^32

        if (master_mode) begin
            if (far_code != CODE_NONE || elapsed > TIME_W'(poll_ms)) begin
                last_poll = req.now_ms;
                if (link_state != ST_CONNECTED && link_state != ST_MAYLOST) begin
                    if (far_code == CODE_HELLO_S) begin
                        link_state = ST_FOUND;
                        send = CODE_ARE_YOU_OK;
                        if (tries != TRIES_SAT) tries++;
                    end else if (far_code == CODE_I_AM_OK) begin
                        link_state = ST_CONNECTED;
                    end else begin
                        send = CODE_HELLO_M;
                        if (tries != TRIES_SAT) tries++;
                    end
                end else if (far_code == CODE_I_AM_HERE) begin
                    tries = '0;
                    link_state = ST_CONNECTED;
                end else if (tries < try_limit) begin
                    send = CODE_STILL_HERE;
                    if (tries != TRIES_SAT) tries++;
                    if (tries == TRIES_ONE)
                        link_state = ST_CONNECTED;
                    else if (tries == TRIES_MAYBE_LOST)
                        link_state = ST_MAYLOST;
                end else begin
                    link_state = ST_LOST;
                end
            end
        end else begin
            // slave answers each master probe and restarts its timeout
            if (far_code == CODE_HELLO_M) begin
                send = CODE_HELLO_S;
                link_state = ST_FOUND;
                last_poll = req.now_ms;
            end else if (far_code == CODE_ARE_YOU_OK) begin
                send = CODE_I_AM_OK;
                link_state = ST_CONNECTED;
                last_poll = req.now_ms;
            end else if (far_code == CODE_STILL_HERE) begin
                send = CODE_I_AM_HERE;
                link_state = ST_CONNECTED;
                last_poll = req.now_ms;
            end else if (elapsed > lost_after) begin
                link_state = ST_LOST;
                last_poll = req.now_ms;
            end else if (elapsed > maybe_after) begin
                link_state = ST_MAYLOST;
            end
        end

        res.link_status  = link_state;
        res.tx_valid     = (send != CODE_NONE);
        res.tx_code      = send;
        res.user_pending = pending;
        res.user_value   = user_val;
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0h actual %0h", $time, field, exp_v, act_v);
        end
    endtask

    // driver: next request goes out at the falling edge once the last one
    // was taken, with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (poll_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= S_DATA_W'(poll_requests.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on every accepted request, check every accepted result
    always @(posedge aclk) begin
        poll_result_t exp_r;
        poll_result_t act_r;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                poll_outcomes.push_back(
                    predict_poll(poll_req_t'(s_tdata[$bits(poll_req_t)-1:0])));
            if (m_tvalid && m_tready) begin
                act_r = poll_result_t'(m_tdata[$bits(poll_result_t)-1:0]);
                if (poll_outcomes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result expected none actual %h", $time, m_tdata);
                end else begin
                    exp_r = poll_outcomes.pop_front();
                    check_field("link_status", 32'(exp_r.link_status),
                                32'(act_r.link_status));
                    check_field("tx_valid", 32'(exp_r.tx_valid), 32'(act_r.tx_valid));
                    check_field("tx_code", 32'(exp_r.tx_code), 32'(act_r.tx_code));
                    check_field("user_pending", 32'(exp_r.user_pending),
                                32'(act_r.user_pending));
                    check_field("user_value", exp_r.user_value, act_r.user_value);
                end
            end
        end
    end

    task automatic push_poll(logic [31:0] now, logic rxv, logic [31:0] rx, logic clr);
        poll_req_t req;
        req.now_ms        = now;
        req.rx_valid      = rxv;
        req.rx_code       = rx;
        req.clear_pending = clr;
        poll_requests.push_back(req);
        stim_now = now;
    endtask

    // wait until every request is in and every result is out, then let the
    // pipeline settle; sampled at the rising edge to stay clear of the driver
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (poll_requests.size() != 0 || s_tvalid || poll_outcomes.size() != 0);
        repeat (LATENCY_SLACK) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_addr_t addr, logic [CFG_DW-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_IS_MASTER: master_mode = data[0];
            REG_POLL_TIME: poll_ms     = data;
            REG_MAX_TRIES: try_limit   = data[TRIES_W-1:0];
            default: ;   // unmapped index is ignored
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // role and timing for the next phase; unused upper bits carry noise
    task automatic apply_setup(logic master, logic [POLL_W-1:0] poll,
                               logic [TRIES_W-1:0] limit);
        wait_drained();
        write_reg(REG_IS_MASTER, {15'($urandom()), master});
        write_reg(REG_POLL_TIME, poll);
        write_reg(REG_MAX_TRIES, {8'($urandom()), limit});
    endtask

    // random polls: time steps aimed at the poll, may-be-lost and lost
    // thresholds, mostly far-side control codes, some own codes and user data
    task automatic queue_random_polls(int unsigned count, int unsigned rx_pct);
        logic [31:0] poll32;
        logic [31:0] maybe_after;
        logic [31:0] lost_after;
        logic [31:0] step;
        logic [31:0] code;
        int unsigned pick;
        logic        rxv;
        poll32      = 32'(poll_ms);
        maybe_after = poll32 + (poll32 >> 1);
        lost_after  = poll32 * 32'(try_limit);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 30)      step = $urandom_range(poll32);
            else if (pick < 50) step = poll32 - 1 + $urandom_range(2);
            else if (pick < 65) step = maybe_after - 1 + $urandom_range(2);
            else if (pick < 78) step = lost_after - 1 + $urandom_range(2);
            else if (pick < 85) step = $urandom();
            else                step = $urandom_range(3);

            code = $urandom();
            rxv  = ($urandom_range(99) < rx_pct);
            if (rxv) begin
                pick = $urandom_range(99);
                if (pick < 60)
                    code = 32'(side_code(!master_mode, $urandom_range(2)));
                else if (pick < 70)
                    code = 32'(side_code(master_mode, $urandom_range(2)));
                else if (pick >= 85)
                    code = $urandom_range(15);
            end
            push_poll(stim_now + step, rxv, code, $urandom_range(5) == 0);
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 85;

        // master at reset defaults: 1000 ms poll, 3 tries
        push_poll(32'd0,    1'b0, 32'hFFFF_FFFF, 1'b0);   // too early, no probe
        push_poll(32'd1001, 1'b0, 32'd0, 1'b0);           // hello
        push_poll(32'd1002, 1'b1, 32'(CODE_HELLO_S), 1'b0);  // found, probe
        push_poll(32'd1003, 1'b1, 32'(CODE_I_AM_OK), 1'b0);  // connected
        push_poll(32'd2004, 1'b0, 32'd0, 1'b0);           // still-here, first try
        push_poll(32'd3005, 1'b0, 32'd0, 1'b0);           // second try, may be lost
        push_poll(32'd3006, 1'b1, 32'(CODE_I_AM_HERE), 1'b0);  // back to connected
        push_poll(32'd4007, 1'b0, 32'd0, 1'b0);
        push_poll(32'd5008, 1'b0, 32'd0, 1'b0);
        push_poll(32'd6009, 1'b0, 32'd0, 1'b0);           // try limit reached
        push_poll(32'd7010, 1'b0, 32'd0, 1'b0);           // lost
        push_poll(32'd7011, 1'b1, 32'hFFFF_FFFF, 1'b0);   // user data, all ones
        push_poll(32'd7012, 1'b1, 32'd0, 1'b1);           // clear then user data zero
        push_poll(32'd7013, 1'b0, 32'd0, 1'b1);           // acknowledge only
        push_poll(32'd7014, 1'b1, 32'hFFFF_FFFF, 1'b0);
        push_poll(32'd7015, 1'b1, 32'(CODE_HELLO_M), 1'b0);  // own code clears flag
        push_poll(32'd7016, 1'b1, 32'd11, 1'b0);          // just past the codes
        push_poll(32'd7017, 1'b1, 32'(CODE_ARE_YOU_OK), 1'b1);
        push_poll(32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0);      // time at top
        push_poll(32'h0000_0100, 1'b0, 32'd0, 1'b0);      // wrap, short elapsed
        push_poll(32'h0000_0400, 1'b0, 32'd0, 1'b0);      // wrap, past poll time
        push_poll(32'h0000_0401, 1'b1, 32'h8000_0006, 1'b0);  // upper bits: user
        push_poll(32'h0000_0402, 1'b1, 32'(CODE_HELLO_S), 1'b0);

        // a write beyond the register list must change nothing
        wait_drained();
        write_reg(REG_UNMAPPED, 16'hFFFF);

        apply_setup(1'b1, 16'd1000, 8'd3);
        queue_random_polls(260, 55);
        apply_setup(1'b0, 16'd1000, 8'd3);   // role change keeps the state
        queue_random_polls(260, 55);
        apply_setup(1'b1, 16'd0, 8'd0);      // zero poll time, zero try limit
        queue_random_polls(180, 50);

        send_idle_pct = 85;
        recv_idle_pct = 30;
        apply_setup(1'b0, 16'd0, 8'd0);
        queue_random_polls(180, 50);
        // nothing heard: the try count runs into saturation
        apply_setup(1'b1, 16'd0, 8'd255);
        repeat (280)
            push_poll(stim_now + 1, 1'b0, $urandom(), $urandom_range(5) == 0);
        queue_random_polls(80, 40);
        apply_setup(1'b1, 16'hFFFF, 8'd255);
        queue_random_polls(170, 55);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setup(1'b0, 16'hFFFF, 8'd255);
        queue_random_polls(170, 55);
        apply_setup(1'b1, 16'($urandom_range(1, 50)), 8'($urandom_range(1, 8)));
        queue_random_polls(150, 55);
        apply_setup(1'b0, 16'($urandom_range(1, 50)), 8'($urandom_range(1, 8)));
        queue_random_polls(150, 55);

        wait_drained();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/lkh_pkg.sv
rtl/lkh_front.sv
rtl/lkh_queue.sv
rtl/lkh_back.sv
rtl/link_keepalive_handshake_unit.sv
bench/tb_link_keepalive_handshake_unit.sv
